// ----- rtl/stb_pkg.sv -----
// Shared types for the software timer bank: operation, status and sequencer codes.
// No dependencies; used by software_timer_bank and stb_slot_ram.
package stb_pkg;

  // Width of each count field in a slot record
  localparam int unsigned COUNT_W = 16;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_TICK    = 2'd2,
    OP_SERVICE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_BAD_ID    = 3'd3,
    ST_TICK_ACK  = 3'd4,
    ST_EXPIRED   = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TICK_RD,
    S_TICK_WR,
    S_TICK_OUT,
    S_SRV
  } state_t;

  // Slot memory record
  typedef struct packed {
    logic [COUNT_W-1:0] duration;
    logic [COUNT_W-1:0] elapsed;
  } slot_rec_t;

endpackage

// ----- rtl/stb_slot_ram.sv -----
// Slot memory of the software timer bank: one record (duration, elapsed) per slot.
// One write port, one read port with registered read data. Depends on stb_pkg.
module stb_slot_ram #(
  parameter int unsigned DEPTH  = 4,
  parameter int unsigned ADDR_W = 2
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  stb_pkg::slot_rec_t  wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output stb_pkg::slot_rec_t  rdata
);

  stb_pkg::slot_rec_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/software_timer_bank.sv -----
// Top level of the software timer bank: command sequencer, per-slot flags and result register.
// Depends on stb_pkg and stb_slot_ram.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  command   | in_valid / in_stall  | op, duration_ms, periodic, timer_id
//  result    | out_valid / out_stall| status, slot_id, last, any_active
//
// Start and cancel place their result from the execute state; a tick walks every slot,
// with one read and one write-back of the slot memory per slot, before its acknowledgement.
// A service walks the slots in order, placing each expiry as the walk reaches its slot
// and flagging the final one as last; an empty service places its result directly.
// A new command is taken once the previous one is finished, even while its last
// result still waits in the output register. Synchronous reset marks every slot idle;
// the slot memory needs no clearing since an idle slot's record is never used.
// A stalled result holds the sequencer at the next result it has to place.
module software_timer_bank #(
  parameter int unsigned TIMER_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] duration_ms,
  input  logic        periodic,
  input  logic [3:0]  timer_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [3:0]  slot_id,
  output logic        last,
  output logic        any_active
);

  localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

  // Control state
  stb_pkg::state_t        state, state_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [TIMER_SLOTS-1:0] active, active_next;
  logic [TIMER_SLOTS-1:0] per_flag, per_flag_next;
  logic [TIMER_SLOTS-1:0] fired, fired_next;
  logic                   srv_any, srv_any_next;
  logic                   out_valid_q, out_valid_next;

  // Command and result payload
  stb_pkg::op_t           op_q;
  logic [15:0]            dur_q;
  logic                   per_q;
  logic [3:0]             id_q;
  stb_pkg::status_t       status_q, status_next;
  logic [3:0]             slot_q, slot_next;
  logic                   last_q, last_next;
  logic                   any_q, any_next;

  // Slot memory port
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  stb_pkg::slot_rec_t     mem_wdata;
  logic                   mem_re;
  stb_pkg::slot_rec_t     mem_rdata;

  // Helpers
  logic                   in_xfer;
  logic                   out_free;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic                   id_ok;
  logic [IDX_W-1:0]       id_idx;
  logic [TIMER_SLOTS-1:0] pend;
  logic                   pend_above;
  logic [15:0]            el_inc;
  logic                   tick_hit;

  assign in_stall   = (state != stb_pkg::S_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_q || !out_stall;
  assign out_valid  = out_valid_q;
  assign status     = status_q;
  assign slot_id    = slot_q;
  assign last       = last_q;
  assign any_active = any_q;

  assign pend     = active & fired;
  assign id_ok    = ({1'b0, id_q} < 5'(TIMER_SLOTS)) && active[id_q[IDX_W-1:0]];
  assign id_idx   = id_q[IDX_W-1:0];
  assign el_inc   = mem_rdata.elapsed + 16'd1;
  assign tick_hit = (el_inc == mem_rdata.duration);

  // Find the lowest idle slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Detect a pending expiry above the current slot
  always_comb begin
    pend_above = 1'b0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (i > int'(idx) && pend[i]) begin
        pend_above = 1'b1;
      end
    end
  end

  // Sequencer: next state, flag updates, memory access and result
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    active_next    = active;
    per_flag_next  = per_flag;
    fired_next     = fired;
    srv_any_next   = srv_any;
    out_valid_next = out_valid_q && out_stall;
    status_next    = status_q;
    slot_next      = slot_q;
    last_next      = last_q;
    any_next       = any_q;
    mem_we         = 1'b0;
    mem_waddr      = idx;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;

    case (state)
      stb_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_next = stb_pkg::S_EXEC;
        end
      end

      stb_pkg::S_EXEC: begin
        case (op_q)
          stb_pkg::OP_START: begin
            if (out_free) begin
              out_valid_next = 1'b1;
              last_next      = 1'b1;
              state_next     = stb_pkg::S_IDLE;
              if (free_found) begin
                active_next[free_idx]   = 1'b1;
                per_flag_next[free_idx] = per_q;
                fired_next[free_idx]    = 1'b0;
                mem_we                  = 1'b1;
                mem_waddr               = free_idx;
                mem_wdata.duration      = dur_q;
                mem_wdata.elapsed       = '0;
                status_next             = stb_pkg::ST_STARTED;
                slot_next               = 4'(free_idx);
                any_next                = 1'b1;
              end else begin
                status_next = stb_pkg::ST_FULL;
                slot_next   = '0;
                any_next    = |active;
              end
            end
          end
          stb_pkg::OP_CANCEL: begin
            if (out_free) begin
              out_valid_next = 1'b1;
              last_next      = 1'b1;
              slot_next      = '0;
              state_next     = stb_pkg::S_IDLE;
              if (id_ok) begin
                active_next[id_idx]   = 1'b0;
                per_flag_next[id_idx] = 1'b0;
                fired_next[id_idx]    = 1'b0;
                status_next           = stb_pkg::ST_CANCELLED;
                any_next              = |active_next;
              end else begin
                status_next = stb_pkg::ST_BAD_ID;
                any_next    = |active;
              end
            end
          end
          stb_pkg::OP_TICK: begin
            idx_next   = '0;
            state_next = stb_pkg::S_TICK_RD;
          end
          stb_pkg::OP_SERVICE: begin
            if (pend == '0) begin
              if (out_free) begin
                out_valid_next = 1'b1;
                status_next    = stb_pkg::ST_NONE;
                slot_next      = '0;
                last_next      = 1'b1;
                any_next       = |active;
                state_next     = stb_pkg::S_IDLE;
              end
            end else begin
              // Active after the walk: every slot but the one-shots that fired
              srv_any_next = |(active & ~(fired & ~per_flag));
              idx_next     = '0;
              state_next   = stb_pkg::S_SRV;
            end
          end
          default: begin
            state_next = stb_pkg::S_IDLE;
          end
        endcase
      end

      // Read the current slot record
      stb_pkg::S_TICK_RD: begin
        mem_re     = 1'b1;
        state_next = stb_pkg::S_TICK_WR;
      end

      // Advance the elapsed count of an active slot (wrap to zero and mark fired on expiry) and write it back
      stb_pkg::S_TICK_WR: begin
        if (active[idx]) begin
          mem_we = 1'b1;
          if (tick_hit) begin
            mem_wdata.elapsed = '0;
            fired_next[idx]   = 1'b1;
          end else begin
            mem_wdata.elapsed = el_inc;
          end
        end
        if (idx == LAST_IDX) begin
          state_next = stb_pkg::S_TICK_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = stb_pkg::S_TICK_RD;
        end
      end

      stb_pkg::S_TICK_OUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = stb_pkg::ST_TICK_ACK;
          slot_next      = '0;
          last_next      = 1'b1;
          any_next       = |active;
          state_next     = stb_pkg::S_IDLE;
        end
      end

      // Walk the slots and report each fired one
      stb_pkg::S_SRV: begin
        if (!pend[idx] || out_free) begin
          if (pend[idx]) begin
            out_valid_next  = 1'b1;
            status_next     = stb_pkg::ST_EXPIRED;
            slot_next       = 4'(idx);
            last_next       = !pend_above;
            any_next        = srv_any;
            fired_next[idx] = 1'b0;
            if (!per_flag[idx]) begin
              active_next[idx] = 1'b0;
            end
          end
          if (idx == LAST_IDX) begin
            state_next = stb_pkg::S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = stb_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stb_pkg::S_IDLE;
      idx         <= '0;
      active      <= '0;
      per_flag    <= '0;
      fired       <= '0;
      srv_any     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      active      <= active_next;
      per_flag    <= per_flag_next;
      fired       <= fired_next;
      srv_any     <= srv_any_next;
      out_valid_q <= out_valid_next;
    end
  end

  // Payload registers: hold the command, load the result
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q  <= stb_pkg::op_t'(op);
      dur_q <= duration_ms;
      per_q <= periodic;
      id_q  <= timer_id;
    end
    status_q <= status_next;
    slot_q   <= slot_next;
    last_q   <= last_next;
    any_q    <= any_next;
  end

  stb_slot_ram #(
    .DEPTH  (TIMER_SLOTS),
    .ADDR_W (IDX_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // A fired mark never outlives its slot
  a_fired_active: assert property (@(posedge clk) disable iff (rst)
    (fired & ~active) == '0)
    else $error("fired mark on idle slot");

  // Only a service gives a result that is not the last one
  a_multi_srv: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |-> (state == stb_pkg::S_SRV))
    else $error("non-final result outside service walk");

  // A started slot leaves the bank active
  a_started_any: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == stb_pkg::ST_STARTED) |-> any_active)
    else $error("started result without active slot");

  // Memory writes come only from a start or a tick write-back
  a_mem_we: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == stb_pkg::S_EXEC || state == stb_pkg::S_TICK_WR))
    else $error("slot memory write outside start or tick");

  // Every tick write-back follows its read
  a_tick_order: assert property (@(posedge clk) disable iff (rst)
    (state == stb_pkg::S_TICK_WR) |-> ($past(state) == stb_pkg::S_TICK_RD))
    else $error("tick write-back without read");
`endif

endmodule
